/* rtl/round_robin_completion_times_assert.svh */
// Assertion macros shared by the round-robin completion time checker.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef ROUND_ROBIN_COMPLETION_TIMES_ASSERT_SVH
`define ROUND_ROBIN_COMPLETION_TIMES_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRCT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("round robin completion times: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RRCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("round robin completion times: next-cycle check failed");

`endif

/* rtl/rrct_pkg.sv */
// Package for the round-robin completion time block: widths, register map,
// sequencer states and the types passed between its modules. No dependencies.
`default_nettype none

package rrct_pkg;

   localparam int ID_W     = 8;
   localparam int BURST_W  = 16;
   localparam int TIME_W   = 20;
   localparam int DATA_W   = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TIME_W-1:0]  TIME_MAX       = 20'hFFFFF;
   localparam logic [BURST_W-1:0] QUANTUM_RESET  = 16'd4;
   // Word index of the quantum register (paddr bit 2).
   localparam logic               REG_IDX_QUANTUM = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN_RD,
      ST_RUN_EX,
      ST_EMIT_RD,
      ST_EMIT_EX
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] remaining;
      logic [TIME_W-1:0]  finish;
   } entry_type;

   typedef struct packed {
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic [TIME_W-1:0] clock_now;
   } alu_in_type;

   typedef struct packed {
      logic               longer;
      logic [BURST_W-1:0] remaining;
      logic [TIME_W-1:0]  clock_next;
      logic [TIME_W-1:0]  diff;
   } alu_out_type;

endpackage

`default_nettype wire

/* rtl/round_robin_completion_times.sv */
// Round-robin scheduler that reports per-job completion and waiting times.
// Top level: rrct_regs for configuration, rrct_sched for table and sequencer.
//
// Usage: each request (start high while busy is low) loads one job, id and
// burst time, into a table of MAX_PROCS entries; a load leaves busy low, so
// loads may follow back to back. Jobs beyond the table size are dropped. The
// request with req_last_job set loads its job and then raises busy while
// round-robin passes run over the table in load order, until a pass finds
// every job done. Each visit to a job is a table read, then one slice
// through the shared subtract and saturating clock add. Results then leave
// in load order, each after its own table read, each marked by a one-cycle
// rsp_valid pulse; the receiver cannot stall and must take each result in
// that cycle. busy falls in the cycle after the result flagged
// rsp_last_result. The quantum register (reset value 4, zero acts as one) is
// written over the APB port; the user must write it only while idle, as the
// block itself does not enforce this.
// Reset returns the sequencer to idle with an empty table.
`default_nettype none

module round_robin_completion_times #(
   parameter int MAX_PROCS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [rrct_pkg::ID_W-1:0]         req_job_id,
   input  wire logic [rrct_pkg::BURST_W-1:0]      req_burst_time,
   input  wire logic                              req_last_job,
   output logic                                   rsp_valid,
   output logic      [rrct_pkg::ID_W-1:0]         rsp_out_job_id,
   output logic      [rrct_pkg::TIME_W-1:0]       rsp_completion_time,
   output logic      [rrct_pkg::TIME_W-1:0]       rsp_turnaround_time,
   output logic      [rrct_pkg::TIME_W-1:0]       rsp_waiting_time,
   output logic                                   rsp_last_result,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [rrct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [rrct_pkg::DATA_W-1:0]       pwdata,
   output logic      [rrct_pkg::DATA_W-1:0]       prdata,
   output logic                                   pready
);
   import rrct_pkg::*;

   logic [BURST_W-1:0] time_quantum;

   rrct_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .time_quantum (time_quantum)
   );

   rrct_sched #(
      .MAX_PROCS (MAX_PROCS)
   ) u_sched (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_job_id          (req_job_id),
      .req_burst_time      (req_burst_time),
      .req_last_job        (req_last_job),
      .time_quantum        (time_quantum),
      .rsp_valid           (rsp_valid),
      .rsp_out_job_id      (rsp_out_job_id),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_last_result     (rsp_last_result)
   );

endmodule

`default_nettype wire

/* rtl/rrct_regs.sv */
// Configuration register file of the round-robin block: holds the time quantum.
// Depends on rrct_pkg.
`default_nettype none

module rrct_regs (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [rrct_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [rrct_pkg::DATA_W-1:0]       pwdata,
   output logic      [rrct_pkg::DATA_W-1:0]       prdata,
   output logic                                   pready,
   output logic      [rrct_pkg::BURST_W-1:0]      time_quantum
);
   import rrct_pkg::*;

   logic [BURST_W-1:0] quantum_ff;
   logic [BURST_W-1:0] quantum_in;
   logic               wr_quantum;

   assign pready     = 1'b1;
   assign wr_quantum = psel && penable && pwrite &&
                       (paddr[CSR_ADDR_W-1] == REG_IDX_QUANTUM);

   always_comb begin
      quantum_in = quantum_ff;
      if (wr_quantum) begin
         quantum_in = pwdata[BURST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
      end else begin
         quantum_ff <= quantum_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == REG_IDX_QUANTUM) begin
         prdata = DATA_W'(quantum_ff);
      end
   end

   assign time_quantum = quantum_ff;

endmodule

`default_nettype wire

/* rtl/rrct_alu.sv */
// Shared arithmetic unit: one subtract-compare and one saturating clock add.
// Serves time slicing and the waiting time result. Depends on rrct_pkg.
`default_nettype none

module rrct_alu (
   input  wire rrct_pkg::alu_in_type  alu_in,
   output rrct_pkg::alu_out_type      alu_out
);
   import rrct_pkg::*;

   logic [TIME_W:0]   diff;
   logic              borrow;
   logic              longer;
   logic [TIME_W-1:0] run_len;
   logic [TIME_W:0]   sum;

   assign diff   = {1'b0, alu_in.a} - {1'b0, alu_in.b};
   assign borrow = diff[TIME_W];
   // a is strictly greater than b: no borrow and a nonzero difference.
   assign longer = !borrow && (diff[TIME_W-1:0] != '0);

   assign run_len = longer ? alu_in.b : alu_in.a;
   assign sum     = {1'b0, alu_in.clock_now} + {1'b0, run_len};

   always_comb begin
      alu_out.longer     = longer;
      alu_out.remaining  = longer ? diff[BURST_W-1:0] : '0;
      alu_out.clock_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      alu_out.diff       = borrow ? '0 : diff[TIME_W-1:0];
   end

endmodule

`default_nettype wire

/* rtl/rrct_sched.sv */
// Job table and sequencer of the round-robin block: loads jobs, runs passes
// through the shared unit and emits results. Depends on rrct_pkg, rrct_alu.
`default_nettype none

module rrct_sched #(
   parameter int MAX_PROCS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rrct_pkg::ID_W-1:0]     req_job_id,
   input  wire logic [rrct_pkg::BURST_W-1:0]  req_burst_time,
   input  wire logic                          req_last_job,
   input  wire logic [rrct_pkg::BURST_W-1:0]  time_quantum,
   output logic                               rsp_valid,
   output logic      [rrct_pkg::ID_W-1:0]     rsp_out_job_id,
   output logic      [rrct_pkg::TIME_W-1:0]   rsp_completion_time,
   output logic      [rrct_pkg::TIME_W-1:0]   rsp_turnaround_time,
   output logic      [rrct_pkg::TIME_W-1:0]   rsp_waiting_time,
   output logic                               rsp_last_result
);
   import rrct_pkg::*;

   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TIME_W-1:0]  clock_ff, clock_in;
   logic               any_ff, any_in;

   entry_type          mem [MAX_PROCS];
   entry_type          rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;

   logic               accept;
   logic               has_room;
   logic               last_idx;
   logic               active;
   logic [BURST_W-1:0] quantum;
   alu_in_type         alu_in;
   alu_out_type        alu_out;

   assign accept   = start && (state_ff == ST_IDLE);
   assign has_room = count_ff < CNT_W'(MAX_PROCS);
   assign last_idx = CNT_W'(idx_ff) == (count_ff - CNT_W'(1));
   assign active   = rd_ff.remaining != '0;
   assign quantum  = (time_quantum == '0) ? BURST_W'(1) : time_quantum;

   always_comb begin
      alu_in.clock_now = clock_ff;
      if (state_ff == ST_EMIT_EX) begin
         alu_in.a = rd_ff.finish;
         alu_in.b = TIME_W'(rd_ff.burst);
      end else begin
         alu_in.a = TIME_W'(rd_ff.remaining);
         alu_in.b = TIME_W'(quantum);
      end
   end

   rrct_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_job) begin
               state_in = ST_RUN_RD;
            end
         end
         ST_RUN_RD: begin
            state_in = ST_RUN_EX;
         end
         ST_RUN_EX: begin
            if (last_idx && !(any_ff || active)) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_RUN_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_EX;
         end
         ST_EMIT_EX: begin
            state_in = last_idx ? ST_IDLE : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Index, job count, scheduling clock and the pass activity flag.
   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      clock_in = clock_ff;
      any_in   = any_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end
               idx_in   = '0;
               clock_in = '0;
               any_in   = 1'b0;
            end
         end
         ST_RUN_EX: begin
            if (active) begin
               clock_in = alu_out.clock_next;
            end
            if (last_idx) begin
               idx_in = '0;
               any_in = 1'b0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               any_in = any_ff || active;
            end
         end
         ST_EMIT_EX: begin
            if (last_idx) begin
               idx_in   = '0;
               count_in = '0;
               clock_in = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Outputs: table writes.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = rd_ff;
      case (state_ff)
         ST_IDLE: begin
            mem_we          = accept && has_room;
            mem_waddr       = count_ff[IDX_W-1:0];
            mem_wdata.id        = req_job_id;
            mem_wdata.burst     = req_burst_time;
            mem_wdata.remaining = req_burst_time;
            mem_wdata.finish    = '0;
         end
         ST_RUN_EX: begin
            mem_we              = active;
            mem_wdata.remaining = alu_out.remaining;
            if (!alu_out.longer) begin
               mem_wdata.finish = alu_out.clock_next;
            end
         end
         default: begin
         end
      endcase
   end

   assign busy                = state_ff != ST_IDLE;
   assign rsp_valid           = state_ff == ST_EMIT_EX;
   assign rsp_out_job_id      = rd_ff.id;
   assign rsp_completion_time = rd_ff.finish;
   assign rsp_turnaround_time = rd_ff.finish;
   assign rsp_waiting_time    = alu_out.diff;
   assign rsp_last_result     = last_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         clock_ff <= '0;
         any_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         clock_ff <= clock_in;
         any_ff   <= any_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/rrct_checker.sv */
// Port-level checker for the round-robin completion time block, bound to the
// top level. Depends on rrct_pkg and round_robin_completion_times_assert.svh.
`default_nettype none

`include "round_robin_completion_times_assert.svh"

module rrct_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          req_last_job,
   input wire logic                          rsp_valid,
   input wire logic [rrct_pkg::TIME_W-1:0]   rsp_completion_time,
   input wire logic [rrct_pkg::TIME_W-1:0]   rsp_turnaround_time,
   input wire logic [rrct_pkg::TIME_W-1:0]   rsp_waiting_time,
   input wire logic                          rsp_last_result
);

   // Results only appear while a job set is being processed.
   `RRCT_ASSERT_NOW(a_result_while_busy, rsp_valid, busy)

   // All jobs arrive at zero, so turnaround equals completion.
   `RRCT_ASSERT_NOW(a_turnaround_is_completion, rsp_valid, rsp_turnaround_time == rsp_completion_time)

   // Waiting time never exceeds completion time.
   `RRCT_ASSERT_NOW(a_waiting_bounded, rsp_valid, rsp_waiting_time <= rsp_completion_time)

   // The final result of a set returns the block to idle.
   `RRCT_ASSERT_NEXT(a_idle_after_last, rsp_valid && rsp_last_result, !busy)

   // A load that does not close the set leaves the block ready.
   `RRCT_ASSERT_NEXT(a_load_keeps_ready, start && !busy && !req_last_job, !busy)

endmodule

bind round_robin_completion_times rrct_checker u_rrct_checker (.*);

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for round_robin_completion_times: directed table, then random job sets.
// Depends on rrct_pkg and the RTL of the block. A scheduler model predicts untyped rows.
`timescale 1ns / 100ps

module tb;
   import rrct_pkg::ID_W;
   import rrct_pkg::BURST_W;
   import rrct_pkg::TIME_W;
   import rrct_pkg::DATA_W;
   import rrct_pkg::CSR_ADDR_W;

   localparam int MAX_JOBS     = 16;
   localparam int RANDOM_JOBS  = 320;
   localparam int STALL_LIMIT  = 200000;
   localparam int MAX_PASSES   = 48;
   localparam int TIME_CAP     = {12'd0, rrct_pkg::TIME_MAX};
   localparam logic [CSR_ADDR_W-1:0] QUANTUM_ADDR = {rrct_pkg::REG_IDX_QUANTUM, 2'b00};

   typedef struct packed {
      logic [ID_W-1:0]   job_id;
      logic [TIME_W-1:0] completion;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              last;
   } job_times_type;

   typedef enum logic {ROW_CFG, ROW_JOB} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] value;
      logic               last;
      logic               typed;
      logic [TIME_W-1:0]  exp_c;
      logic [TIME_W-1:0]  exp_w;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ID_W-1:0]    req_job_id = '0;
   logic [BURST_W-1:0] req_burst_time = '0;
   logic               req_last_job = 1'b0;
   logic               rsp_valid;
   logic [ID_W-1:0]    rsp_out_job_id;
   logic [TIME_W-1:0]  rsp_completion_time;
   logic [TIME_W-1:0]  rsp_turnaround_time;
   logic [TIME_W-1:0]  rsp_waiting_time;
   logic               rsp_last_result;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0]  pwdata = '0;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   // Local copy of the job table and the quantum register.
   logic [BURST_W-1:0] quantum_cfg = rrct_pkg::QUANTUM_RESET;
   int                 table_count = 0;
   logic [ID_W-1:0]    table_ids    [MAX_JOBS];
   logic [BURST_W-1:0] table_bursts [MAX_JOBS];
   logic               table_typed  [MAX_JOBS];
   logic [TIME_W-1:0]  table_exp_c  [MAX_JOBS];
   logic [TIME_W-1:0]  table_exp_w  [MAX_JOBS];

   job_times_type expected_times[$];
   int mismatches = 0;
   int stall_cycles = 0;
   int burst_left = 0;
   int jobs_sent = 0;
   int phase = 0;
   int set_jobs;
   int sets_left;
   int q_eff;

   // Quantum 4 from reset, then 65535, zero (acts as one), one and three.
   dir_row_type directed_rows [29] = '{
      '{ROW_JOB, 8'h00, 16'd0,     1'b1, 1'b1, 20'd0,      20'd0},
      '{ROW_JOB, 8'hFF, 16'd65535, 1'b1, 1'b1, 20'd65535,  20'd0},
      '{ROW_CFG, 8'h00, 16'd65535, 1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'hAA, 16'd65535, 1'b0, 1'b1, 20'd65535,  20'd0},
      '{ROW_JOB, 8'h55, 16'd65535, 1'b1, 1'b1, 20'd131070, 20'd65535},
      '{ROW_CFG, 8'h00, 16'd0,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h01, 16'd3,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h02, 16'd0,     1'b0, 1'b1, 20'd0,      20'd0},
      '{ROW_JOB, 8'h03, 16'd2,     1'b1, 1'b0, 20'd0,      20'd0},
      '{ROW_CFG, 8'h00, 16'd1,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h80, 16'd1,     1'b1, 1'b1, 20'd1,      20'd0},
      '{ROW_CFG, 8'h00, 16'd3,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h10, 16'd5,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h11, 16'd0,     1'b0, 1'b1, 20'd0,      20'd0},
      '{ROW_JOB, 8'h12, 16'd7,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h13, 16'd3,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h14, 16'd12,    1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h15, 16'd1,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h16, 16'd9,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h17, 16'd4,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h18, 16'd6,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h19, 16'd2,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h1A, 16'd10,    1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h1B, 16'd8,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h1C, 16'd11,    1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h1D, 16'd3,     1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h1E, 16'd14,    1'b0, 1'b0, 20'd0,      20'd0},
      '{ROW_JOB, 8'h1F, 16'd1,     1'b0, 1'b0, 20'd0,      20'd0},
      // The table is full here, so this job is dropped but still starts the passes.
      '{ROW_JOB, 8'hEE, 16'd9,     1'b1, 1'b0, 20'd0,      20'd0}
   };

   round_robin_completion_times uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_job_id(req_job_id), .req_burst_time(req_burst_time), .req_last_job(req_last_job),
      .rsp_valid(rsp_valid), .rsp_out_job_id(rsp_out_job_id),
      .rsp_completion_time(rsp_completion_time), .rsp_turnaround_time(rsp_turnaround_time),
      .rsp_waiting_time(rsp_waiting_time), .rsp_last_result(rsp_last_result),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Loads one job into the local table; a job marked last runs the round-robin
   // passes and queues one set of times per stored job, in load order.
   function automatic void load_job(input logic [ID_W-1:0] id, input logic [BURST_W-1:0] burst,
                                    input logic last, input logic typed,
                                    input logic [TIME_W-1:0] exp_c,
                                    input logic [TIME_W-1:0] exp_w);
      int q;
      int now;
      int k;
      int remain [MAX_JOBS];
      int fin [MAX_JOBS];
      bit running;
      job_times_type times;
      if (table_count < MAX_JOBS) begin
         table_ids[table_count]    = id;
         table_bursts[table_count] = burst;
         table_typed[table_count]  = typed;
         table_exp_c[table_count]  = exp_c;
         table_exp_w[table_count]  = exp_w;
         table_count++;
      end
      if (!last)
         return;
      q = (quantum_cfg == 0) ? 1 : int'(quantum_cfg);
      for (k = 0; k < table_count; k++) begin
         remain[k] = int'(table_bursts[k]);
         fin[k] = 0;
      end
      now = 0;
      running = 1'b1;
      while (running) begin
         running = 1'b0;
         for (k = 0; k < table_count; k++) begin
            if (remain[k] != 0) begin
               running = 1'b1;
               if (remain[k] > q) begin
                  now = now + q;
                  remain[k] = remain[k] - q;
               end else begin
                  now = now + remain[k];
                  remain[k] = 0;
               end
               if (now > TIME_CAP)
                  now = TIME_CAP;
               if (remain[k] == 0)
                  fin[k] = now;
            end
         end
      end
      for (k = 0; k < table_count; k++) begin
         times.job_id     = table_ids[k];
         times.completion = TIME_W'(fin[k]);
         times.turnaround = TIME_W'(fin[k]);
         times.waiting    = (fin[k] >= int'(table_bursts[k])) ?
                            TIME_W'(fin[k] - int'(table_bursts[k])) : '0;
         times.last       = (k == table_count - 1);
         if (table_typed[k]) begin
            times.completion = table_exp_c[k];
            times.turnaround = table_exp_c[k];
            times.waiting    = table_exp_w[k];
         end
         expected_times.push_back(times);
      end
      table_count = 0;
   endfunction

   function automatic logic [BURST_W-1:0] pick_burst(input int q);
      int cap;
      int sel;
      cap = q * MAX_PASSES;
      if (cap > 65535)
         cap = 65535;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return '0;
      else if (sel == 1)
         return BURST_W'(cap);
      return BURST_W'($urandom_range(0, cap));
   endfunction

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      req_job_id <= ID_W'($urandom_range(0, 255));
      req_burst_time <= BURST_W'($urandom_range(0, 65535));
      req_last_job <= 1'($urandom_range(0, 1));
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_job(input logic [ID_W-1:0] id, input logic [BURST_W-1:0] burst,
                           input logic last, input logic typed,
                           input logic [TIME_W-1:0] exp_c, input logic [TIME_W-1:0] exp_w);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 7));
      end
      burst_left--;
      start <= 1'b1;
      req_job_id <= id;
      req_burst_time <= burst;
      req_last_job <= last;
      do
         @(posedge clock);
      while (busy);
      load_job(id, burst, last, typed, exp_c, exp_w);
   endtask

   // Holds the sender off until every expected result has come and busy is low.
   task automatic wait_idle();
      pause_sender(1);
      while (expected_times.size() != 0 || busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [BURST_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= QUANTUM_ADDR;
      pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      quantum_cfg = value;
      pwrite <= 1'b0;
      penable <= 1'b0;
      pwdata <= $urandom;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[BURST_W-1:0] !== quantum_cfg) begin
         if (mismatches < 10)
            $display("quantum read back: expected %0d, got %0d", quantum_cfg,
                     prdata[BURST_W-1:0]);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      job_times_type got;
      job_times_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_out_job_id, rsp_completion_time, rsp_turnaround_time,
                rsp_waiting_time, rsp_last_result};
         if (expected_times.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: id %0d completion %0d", got.job_id, got.completion);
            mismatches++;
         end else begin
            want = expected_times.pop_front();
            if (got !== want) begin
               if (mismatches < 10)
                  $display("result mismatch: expected id %0d c %0d t %0d w %0d last %b,",
                           want.job_id, want.completion, want.turnaround, want.waiting,
                           want.last,
                           " got id %0d c %0d t %0d w %0d last %b",
                           got.job_id, got.completion, got.turnaround, got.waiting,
                           got.last);
               mismatches++;
            end
         end
      end
   end

   // Counts cycles in which no request, result or register access completes.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            wait_idle();
            write_quantum(directed_rows[i].value);
         end else
            send_job(directed_rows[i].id, directed_rows[i].value, directed_rows[i].last,
                     directed_rows[i].typed, directed_rows[i].exp_c, directed_rows[i].exp_w);
      end

      while (jobs_sent < RANDOM_JOBS) begin
         wait_idle();
         case (phase)
            0: write_quantum(16'd65535);
            1: write_quantum(16'd1);
            2: write_quantum(16'd0);
            3: write_quantum(BURST_W'($urandom_range(2, 16)));
            default: begin
               if ($urandom_range(0, 1) == 0)
                  write_quantum(BURST_W'($urandom_range(1, 64)));
               else
                  write_quantum(BURST_W'($urandom_range(0, 65535)));
            end
         endcase
         phase++;
         q_eff = (quantum_cfg == 0) ? 1 : int'(quantum_cfg);
         sets_left = $urandom_range(3, 7);
         while (sets_left > 0) begin
            // Most sets fit the table; a few overflow it so the extra jobs are dropped.
            if ($urandom_range(0, 9) == 0)
               set_jobs = $urandom_range(17, 20);
            else
               set_jobs = $urandom_range(1, MAX_JOBS);
            for (int j = 0; j < set_jobs; j++) begin
               if (j < MAX_JOBS)
                  jobs_sent++;
               send_job(ID_W'($urandom_range(0, 255)), pick_burst(q_eff), j == set_jobs - 1,
                        1'b0, '0, '0);
            end
            sets_left--;
         end
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && expected_times.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/rrct_pkg.sv
rtl/rrct_regs.sv
rtl/rrct_alu.sv
rtl/rrct_sched.sv
rtl/round_robin_completion_times.sv
rtl/rrct_checker.sv
sim/tb.sv
